// ----- rtl/assert_macros.svh -----
// Assertion helpers, clocked on i_clk and quiet during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/lrt_pkg.sv -----
package lrt_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int KEY_SPACE       = 256;
    localparam int KEY_W           = 8;
    localparam int CAP_W           = 5;
    localparam int FILL_W          = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        logic capture;  // latch key and list compare
        logic update;   // apply the access, load the result register
    } t_cmd;

endpackage

// ----- rtl/lrt_if.sv -----
interface lrt_in_if;
    logic                      valid;
    logic                      ready;
    logic [lrt_pkg::KEY_W-1:0] key;

    modport source (output valid, output key, input ready);
    modport sink   (input valid, input key, output ready);
endinterface

interface lrt_out_if;
    logic                       valid;
    logic                       ready;
    logic                       hit;
    logic                       evicted;
    logic [lrt_pkg::KEY_W-1:0]  evicted_key;
    logic [lrt_pkg::FILL_W-1:0] fill_level;
    logic                       key_error;

    modport source (output valid, output hit, output evicted, output evicted_key,
                    output fill_level, output key_error, input ready);
    modport sink   (input valid, input hit, input evicted, input evicted_key,
                    input fill_level, input key_error, output ready);
endinterface

// ----- rtl/lrt_ctrl.sv -----
module lrt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output lrt_pkg::t_cmd o_cmd
);

    lrt_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lrt_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = lrt_pkg::ST_UPDATE;
            end
            lrt_pkg::ST_UPDATE: begin
                if (!r_out_valid || i_out_ready) n_state = lrt_pkg::ST_IDLE;
            end
            default: n_state = lrt_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.update  = 1'b0;
        case (r_state)
            lrt_pkg::ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            lrt_pkg::ST_UPDATE: begin
                // wait for the result register to free up
                o_cmd.update = !r_out_valid || i_out_ready;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
        if (o_cmd.update) n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
        else n_out_valid = r_out_valid;
    end

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lrt_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ----- rtl/lrt_datapath.sv -----
module lrt_datapath #(
    parameter int MAX_ENTRIES = lrt_pkg::MAX_ENTRIES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lrt_pkg::t_cmd               i_cmd,
    input  logic [lrt_pkg::KEY_W-1:0]   i_key,
    input  logic                        i_cfg_we,
    input  logic [lrt_pkg::CAP_W-1:0]   i_cfg_wdata,
    output logic                        o_hit,
    output logic                        o_evicted,
    output logic [lrt_pkg::KEY_W-1:0]   o_evicted_key,
    output logic [lrt_pkg::FILL_W-1:0]  o_fill_level,
    output logic                        o_key_error
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [MAX_ENTRIES-1:0] ONES = '1;

    // recency list: position 0 least recent, r_count-1 most recent
    logic [lrt_pkg::KEY_W-1:0] r_list [MAX_ENTRIES];
    logic [lrt_pkg::KEY_W-1:0] n_list [MAX_ENTRIES];
    logic [lrt_pkg::KEY_W-1:0] w_up   [MAX_ENTRIES];
    logic [CW-1:0]             r_count, n_count;
    logic [lrt_pkg::CAP_W-1:0] r_cap;

    logic [lrt_pkg::KEY_W-1:0] r_key;
    logic                      r_err;
    logic [MAX_ENTRIES-1:0]    r_match, n_match;

    logic                      r_hit, n_hit;
    logic                      r_evicted, n_evicted;
    logic [lrt_pkg::KEY_W-1:0] r_evkey, n_evkey;
    logic                      r_kerr;

    logic [MAX_ENTRIES-1:0]    w_ge, w_sh;
    logic [7:0]                w_cnt8, w_cap8, w_eff8;
    logic [CW-1:0]             w_wpos;

    // compare the incoming key against every resident entry
    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            n_match[i] = (r_list[i] == i_key) && (CW'(i) < r_count);
        end
    end

    always_comb begin
        w_cnt8 = 8'(r_count);
        w_cap8 = 8'(r_cap);
        if (w_cap8 == 8'd0) w_eff8 = 8'd1;
        else if (w_cap8 > 8'(MAX_ENTRIES)) w_eff8 = 8'(MAX_ENTRIES);
        else w_eff8 = w_cap8;

        n_hit     = !r_err && (|r_match);
        n_evicted = !r_err && !n_hit && (w_cnt8 >= w_eff8) && (w_cnt8 != 8'd0);
        n_evkey   = n_evicted ? r_list[0] : '0;

        // entries at and above the hit position shift down one place; on an eviction all entries do
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            w_ge[i] = |(r_match & ~(ONES << (i + 1)));
            w_sh[i] = n_hit ? w_ge[i] : n_evicted;
        end
        for (int i = 0; i < MAX_ENTRIES - 1; i++) begin
            w_up[i] = r_list[i + 1];
        end
        w_up[MAX_ENTRIES-1] = r_list[MAX_ENTRIES-1];

        w_wpos = (n_hit || n_evicted) ? r_count - CW'(1) : r_count;

        for (int i = 0; i < MAX_ENTRIES; i++) begin
            n_list[i] = r_list[i];
            if (!r_err) begin
                if (CW'(i) == w_wpos) n_list[i] = r_key;
                else if (w_sh[i]) n_list[i] = w_up[i];
            end
        end

        if (!r_err && !n_hit && !n_evicted) n_count = r_count + CW'(1);
        else n_count = r_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_cap   <= lrt_pkg::CAP_RESET;
        end else begin
            if (i_cfg_we) r_cap <= i_cfg_wdata;
            if (i_cmd.update) r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_key   <= i_key;
            r_err   <= int'({24'd0, i_key}) >= lrt_pkg::KEY_SPACE;
            r_match <= n_match;
        end
        if (i_cmd.update) begin
            r_list    <= n_list;
            r_hit     <= n_hit;
            r_evicted <= n_evicted;
            r_evkey   <= n_evkey;
            r_kerr    <= r_err;
        end
    end

    // fill level is the count after the access, truncated to the field width
    logic [lrt_pkg::FILL_W-1:0] r_fill;
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) r_fill <= lrt_pkg::FILL_W'(n_count);
    end

    assign o_hit         = r_hit;
    assign o_evicted     = r_evicted;
    assign o_evicted_key = r_evkey;
    assign o_fill_level  = r_fill;
    assign o_key_error   = r_kerr;

endmodule

// ----- rtl/lru_replacement_tracker_top.sv -----
// LRU replacement tracker.
// i_in_ch carries one key per item; each item yields exactly one result on
// o_out_ch: hit, evicted, evicted_key, fill_level and key_error. Both
// channels use valid/ready; an item moves on an edge with both high.
// i_cfg_we/i_cfg_wdata write the capacity register (reset value 16, zero
// acts as one, values above MAX_ENTRIES act as MAX_ENTRIES); write it only
// while no access is in flight.
// Sequence: an accepted key is captured with its parallel compare against
// the recency list, then ST_UPDATE applies the shift/append update and
// loads the result register once it is free. One item is processed at a
// time: no new key is accepted until that update is done.
// If the receiver stalls, the result holds in the output register; a new
// key is still accepted, and its update waits until the old result leaves.
// Reset (synchronous, active low) empties the list and drops any pending
// result; residency is decided by the compare, so no clearing pass exists.
module lru_replacement_tracker_top #(
    parameter int MAX_ENTRIES = lrt_pkg::MAX_ENTRIES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    lrt_in_if.sink                    i_in_ch,
    lrt_out_if.source                 o_out_ch,
    input  logic                      i_cfg_we,
    input  logic [lrt_pkg::CAP_W-1:0] i_cfg_wdata
);

    lrt_pkg::t_cmd w_cmd;

    lrt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_ch.valid),
        .o_in_ready  (i_in_ch.ready),
        .o_out_valid (o_out_ch.valid),
        .i_out_ready (o_out_ch.ready),
        .o_cmd       (w_cmd)
    );

    lrt_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_key         (i_in_ch.key),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_hit         (o_out_ch.hit),
        .o_evicted     (o_out_ch.evicted),
        .o_evicted_key (o_out_ch.evicted_key),
        .o_fill_level  (o_out_ch.fill_level),
        .o_key_error   (o_out_ch.key_error)
    );

`include "assert_macros.svh"

    `ASSERT_SAME(a_hit_no_evict, o_out_ch.valid, !(o_out_ch.hit && o_out_ch.evicted), "hit and evict together")
    `ASSERT_SAME(a_err_quiet, o_out_ch.valid && o_out_ch.key_error, !o_out_ch.hit && !o_out_ch.evicted, "key error with list change")
    `ASSERT_NEXT(a_one_in_flight, i_in_ch.valid && i_in_ch.ready, !i_in_ch.ready, "second item accepted in flight")
    `ASSERT_SAME(a_fill_bound, o_out_ch.valid, {3'b000, o_out_ch.fill_level} <= 8'(MAX_ENTRIES), "fill level above entries")

endmodule

// ----- bench/lru_replacement_tracker_top_tb.sv -----
`timescale 1ns / 1ps

module lru_replacement_tracker_top_tb;

    localparam int MAX_ENTRIES = lrt_pkg::MAX_ENTRIES_DEF;
    localparam int CYCLE_LIMIT = 100000;
    localparam int SEG_ITEMS   = 62;
    localparam int NUM_SEGS    = 12;
    localparam int POOL_SIZE   = 24;

    typedef struct packed {
        logic                       hit;
        logic                       evicted;
        logic [lrt_pkg::KEY_W-1:0]  evicted_key;
        logic [lrt_pkg::FILL_W-1:0] fill_level;
        logic                       key_error;
    } t_access_result;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      cfg_we;
    logic [lrt_pkg::CAP_W-1:0] cfg_wdata;

    lrt_in_if  in_ch ();
    lrt_out_if out_ch ();

    lru_replacement_tracker_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_ch     (in_ch),
        .o_out_ch    (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // predictor state
    logic [lrt_pkg::KEY_W-1:0] lru_keys [MAX_ENTRIES];
    int                        lru_count;
    logic                      resident [lrt_pkg::KEY_SPACE];
    int                        cap_reg;

    logic [lrt_pkg::KEY_W-1:0] key_queue [$];
    t_access_result            result_queue [$];
    int                        items_queued;
    int                        results_seen;
    int                        errors;
    int                        cycles;
    int                        src_idle_pct;
    int                        snk_idle_pct;
    logic                      in_taken;

    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_access_result predict_access(input logic [lrt_pkg::KEY_W-1:0] key);
        t_access_result r;
        int             pos;
        int             eff;
        int             i;
        r = '0;
        eff = (cap_reg == 0) ? 1 : ((cap_reg > MAX_ENTRIES) ? MAX_ENTRIES : cap_reg);
        if (int'(key) >= lrt_pkg::KEY_SPACE) begin
            r.key_error = 1'b1;
        end else begin
            pos = lru_count;
            if (resident[key]) begin
                for (i = 0; i < lru_count; i++) begin
                    if (lru_keys[i] == key && pos == lru_count)
                        pos = i;
                end
            end
            if (pos < lru_count) begin
                r.hit = 1'b1;
                for (i = pos; i + 1 < lru_count; i++)
                    lru_keys[i] = lru_keys[i+1];
                lru_keys[lru_count-1] = key;
            end else begin
                // full (or over a lowered capacity): drop the oldest first
                if (lru_count >= eff && lru_count > 0) begin
                    r.evicted     = 1'b1;
                    r.evicted_key = lru_keys[0];
                    resident[lru_keys[0]] = 1'b0;
                    for (i = 0; i + 1 < lru_count; i++)
                        lru_keys[i] = lru_keys[i+1];
                    lru_count--;
                end
                if (lru_count < MAX_ENTRIES) begin
                    lru_keys[lru_count] = key;
                    lru_count++;
                    resident[key] = 1'b1;
                end
            end
        end
        r.fill_level = lru_count[lrt_pkg::FILL_W-1:0];
        return r;
    endfunction

    task automatic send_key(input int key);
        key_queue.push_back(key[lrt_pkg::KEY_W-1:0]);
        items_queued++;
    endtask

    task automatic wait_drained();
        while (results_seen < items_queued)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_capacity(input int value);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value[lrt_pkg::CAP_W-1:0];
        cap_reg = value & 5'h1f;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // item driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid  <= 1'b0;
            in_ch.key    <= '0;
            out_ch.ready <= 1'b0;
        end else begin
            if (!in_ch.valid || in_taken) begin
                if (key_queue.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                    in_ch.valid <= 1'b1;
                    in_ch.key   <= key_queue.pop_front();
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
            out_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // accept monitor, result checker, watchdog
    always @(posedge i_clk) begin
        t_access_result got;
        t_access_result exp;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= in_ch.valid && in_ch.ready;
            if (in_ch.valid && in_ch.ready)
                result_queue.push_back(predict_access(in_ch.key));
            if (out_ch.valid && out_ch.ready) begin
                got.hit         = out_ch.hit;
                got.evicted     = out_ch.evicted;
                got.evicted_key = out_ch.evicted_key;
                got.fill_level  = out_ch.fill_level;
                got.key_error   = out_ch.key_error;
                results_seen++;
                if (result_queue.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result hit=%0d ev=%0d ev_key=%0d fill=%0d err=%0d",
                             $time, got.hit, got.evicted, got.evicted_key,
                             got.fill_level, got.key_error);
                end else begin
                    exp = result_queue.pop_front();
                    if (got.hit !== exp.hit || got.evicted !== exp.evicted ||
                        got.evicted_key !== exp.evicted_key ||
                        got.fill_level !== exp.fill_level ||
                        got.key_error !== exp.key_error) begin
                        errors++;
                        $display("%0t: mismatch exp hit=%0d ev=%0d ev_key=%0d fill=%0d err=%0d",
                                 $time, exp.hit, exp.evicted, exp.evicted_key,
                                 exp.fill_level, exp.key_error);
                        $display("%0t:          got hit=%0d ev=%0d ev_key=%0d fill=%0d err=%0d",
                                 $time, got.hit, got.evicted, got.evicted_key,
                                 got.fill_level, got.key_error);
                    end
                end
            end
        end
    end

    initial begin
        int seg_caps [NUM_SEGS];
        int pool [POOL_SIZE];
        int seg;
        int n;
        int eff;
        int pool_n;
        int k;

        seg_caps = '{16, 1, 31, 0, 4, 9, 2, 15, 17, 7, 12, 0};
        seg_caps[NUM_SEGS-1] = $urandom_range(0, 31);

        i_rst_n      = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        in_ch.valid  = 1'b0;
        in_ch.key    = '0;
        out_ch.ready = 1'b0;
        in_taken     = 1'b0;
        items_queued = 0;
        results_seen = 0;
        errors       = 0;
        cycles       = 0;
        src_idle_pct = 14;
        snk_idle_pct = 79;
        lru_count    = 0;
        cap_reg      = int'(lrt_pkg::CAP_RESET);
        for (k = 0; k < MAX_ENTRIES; k++)
            lru_keys[k] = '0;
        for (k = 0; k < lrt_pkg::KEY_SPACE; k++)
            resident[k] = 1'b0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // capacity one from empty: second key replaces the first
        write_capacity(1);
        send_key(10);
        send_key(11);
        send_key(11);
        wait_drained();

        // fill to the top, then evict in recency order
        write_capacity(16);
        send_key(0);
        send_key(255);
        send_key(0);
        send_key(1);   send_key(2);   send_key(4);   send_key(8);
        send_key(16);  send_key(32);  send_key(64);  send_key(127);
        send_key(170); send_key(85);  send_key(254); send_key(3);
        send_key(240);
        send_key(99);
        send_key(11);
        wait_drained();

        // zero acts as one while the list stays over capacity
        write_capacity(0);
        send_key(99);
        send_key(7);
        wait_drained();

        // above the list size saturates
        write_capacity(31);
        send_key(7);
        send_key(200);
        wait_drained();

        for (seg = 0; seg < NUM_SEGS; seg++) begin
            case (seg / 4)
                0: begin
                    src_idle_pct = 14;
                    snk_idle_pct = 79;
                end
                1: begin
                    src_idle_pct = 79;
                    snk_idle_pct = 14;
                end
                default: begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            write_capacity(seg_caps[seg]);
            eff = (cap_reg == 0) ? 1 : ((cap_reg > MAX_ENTRIES) ? MAX_ENTRIES : cap_reg);
            pool_n = eff + 3;
            for (k = 0; k < POOL_SIZE; k++)
                pool[k] = $urandom_range(0, lrt_pkg::KEY_SPACE - 1);
            // working set slightly larger than capacity gives a hit/miss mix
            for (n = 0; n < SEG_ITEMS; n++) begin
                if ($urandom_range(0, 99) < 80)
                    send_key(pool[$urandom_range(0, pool_n - 1)]);
                else
                    send_key($urandom_range(0, lrt_pkg::KEY_SPACE - 1));
            end
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        if (errors == 0 && result_queue.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/lrt_pkg.sv
rtl/lrt_if.sv
rtl/lrt_ctrl.sv
rtl/lrt_datapath.sv
rtl/lru_replacement_tracker_top.sv
bench/lru_replacement_tracker_top_tb.sv
